// File: sv/qvr_pkg.sv
// Shared types and constants of the quaternion vector rotation core.
`default_nettype none

package qvr_pkg;

    // Quaternion part width (Q2.14 by default) and product widths
    localparam int QW = 16;
    localparam int PW = 2 * QW;
    // Rotation matrix entries need two bits over one product
    localparam int CW = PW + 2;

    // Configuration register index port width
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q_W = 8'd0,
        CFG_Q_X = 8'd1,
        CFG_Q_Y = 8'd2,
        CFG_Q_Z = 8'd3
    } cfg_index_t;

    // Reset value of the scalar part: 1.0 in Q2.14
    localparam logic [QW-1:0] Q_W_RESET = 16'd16384;

    typedef logic signed [QW-1:0] quat_part_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [CW-1:0] coef_t;

    // Orientation quaternion as held by the register file
    typedef struct packed {
        quat_part_t w;
        quat_part_t x;
        quat_part_t y;
        quat_part_t z;
    } quat_t;

    // Sign-extend a quaternion product to matrix entry width
    function automatic coef_t ext_prod(prod_t p);
        return {{(CW - PW){p[PW-1]}}, p};
    endfunction

    // Twice a matrix entry difference; the operand fits CW-1 bits
    function automatic coef_t twice(coef_t d);
        return {d[CW-2:0], 1'b0};
    endfunction

endpackage

`default_nettype wire

// File: sv/qvr_cfg.sv
// Configuration register file holding the orientation quaternion.
`default_nettype none

module qvr_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [qvr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [qvr_pkg::QW-1:0]        cfg_data,
    output qvr_pkg::quat_t                     quat
);
    import qvr_pkg::*;

    quat_t quat_reg;
    quat_t quat_next;

    // Decode the register index; ignore indexes beyond the list
    always_comb
    begin
        quat_next = quat_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_Q_W: quat_next.w = cfg_data;
                CFG_Q_X: quat_next.x = cfg_data;
                CFG_Q_Y: quat_next.y = cfg_data;
                CFG_Q_Z: quat_next.z = cfg_data;
                default: quat_next   = quat_reg;
            endcase
        end
    end

    // Hold the quaternion, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.w <= Q_W_RESET;
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
        end
        else
        begin
            quat_reg <= quat_next;
        end
    end

    assign quat = quat_reg;

endmodule

`default_nettype wire

// File: sv/qvr_coef.sv
// Front stages: quaternion products and rotation matrix, vector delayed alongside.
`default_nettype none

module qvr_coef #(
    parameter int VEC_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  en1,
    input  wire logic                  en2,
    input  wire qvr_pkg::quat_t        quat,
    input  wire logic signed [VEC_WIDTH-1:0] vec_in [3],
    output qvr_pkg::coef_t             coef [3][3],
    output logic signed [VEC_WIDTH-1:0] vec_out [3]
);
    import qvr_pkg::*;

    prod_t ww_reg, xx_reg, yy_reg, zz_reg;
    prod_t xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [VEC_WIDTH-1:0] vec1_reg [3];
    logic signed [VEC_WIDTH-1:0] vec2_reg [3];
    coef_t coef_reg [3][3];
    coef_t coef_next [3][3];

    // Stage 1: all pairwise products of the quaternion parts
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ww_reg   <= quat.w * quat.w;
            xx_reg   <= quat.x * quat.x;
            yy_reg   <= quat.y * quat.y;
            zz_reg   <= quat.z * quat.z;
            xy_reg   <= quat.x * quat.y;
            wz_reg   <= quat.w * quat.z;
            xz_reg   <= quat.x * quat.z;
            wy_reg   <= quat.w * quat.y;
            yz_reg   <= quat.y * quat.z;
            wx_reg   <= quat.w * quat.x;
            vec1_reg <= vec_in;
        end
    end

    // Combine products into the rotation matrix
    always_comb
    begin
        coef_next[0][0] = ext_prod(ww_reg) + ext_prod(xx_reg) - ext_prod(yy_reg)
                          - ext_prod(zz_reg);
        coef_next[0][1] = twice(ext_prod(xy_reg) - ext_prod(wz_reg));
        coef_next[0][2] = twice(ext_prod(xz_reg) + ext_prod(wy_reg));
        coef_next[1][0] = twice(ext_prod(xy_reg) + ext_prod(wz_reg));
        coef_next[1][1] = ext_prod(ww_reg) - ext_prod(xx_reg) + ext_prod(yy_reg)
                          - ext_prod(zz_reg);
        coef_next[1][2] = twice(ext_prod(yz_reg) - ext_prod(wx_reg));
        coef_next[2][0] = twice(ext_prod(xz_reg) - ext_prod(wy_reg));
        coef_next[2][1] = twice(ext_prod(yz_reg) + ext_prod(wx_reg));
        coef_next[2][2] = ext_prod(ww_reg) - ext_prod(xx_reg) - ext_prod(yy_reg)
                          + ext_prod(zz_reg);
    end

    // Stage 2: register the matrix and advance the vector
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            coef_reg <= coef_next;
            vec2_reg <= vec1_reg;
        end
    end

    assign coef    = coef_reg;
    assign vec_out = vec2_reg;

endmodule

`default_nettype wire

// File: sv/qvr_row.sv
// Back stages for one output component: multiply, sum and round, saturate.
`default_nettype none

module qvr_row #(
    parameter int VEC_WIDTH      = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic                        clk,
    input  wire logic                        en3,
    input  wire logic                        en4,
    input  wire logic                        en5,
    input  wire qvr_pkg::coef_t              coef [3],
    input  wire logic signed [VEC_WIDTH-1:0] vec [3],
    output logic signed [VEC_WIDTH-1:0]      rot,
    output logic                             sat
);
    import qvr_pkg::*;

    localparam int MW   = CW + VEC_WIDTH;
    localparam int SUMW = MW + 2;
    localparam int SH   = 2 * QUAT_FRAC_BITS;
    localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (SH - 1);
    localparam logic signed [SUMW-1:0] VMAX =
        {{(SUMW - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [SUMW-1:0] VMIN =
        {{(SUMW - VEC_WIDTH + 1){1'b1}}, {(VEC_WIDTH - 1){1'b0}}};

    logic signed [MW-1:0]        prod_reg [3];
    logic signed [SUMW-1:0]      sum_next;
    logic signed [SUMW-1:0]      rnd_reg;
    logic signed [VEC_WIDTH-1:0] rot_next;
    logic                        sat_next;
    logic signed [VEC_WIDTH-1:0] rot_reg;
    logic                        sat_reg;

    // Stage 3: one full-precision product per matrix entry
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= MW'(coef[k]) * MW'(vec[k]);
            end
        end
    end

    // Add the three products and one half, then drop the fraction
    assign sum_next = SUMW'(prod_reg[0]) + SUMW'(prod_reg[1]) + SUMW'(prod_reg[2]) + HALF;

    // Stage 4: rounded component
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            rnd_reg <= sum_next >>> SH;
        end
    end

    // Clip to the output range
    always_comb
    begin
        priority if (rnd_reg > VMAX)
        begin
            rot_next = VMAX[VEC_WIDTH-1:0];
            sat_next = 1'b1;
        end
        else if (rnd_reg < VMIN)
        begin
            rot_next = VMIN[VEC_WIDTH-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            rot_next = rnd_reg[VEC_WIDTH-1:0];
            sat_next = 1'b0;
        end
    end

    // Stage 5: output register
    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            rot_reg <= rot_next;
            sat_reg <= sat_next;
        end
    end

    assign rot = rot_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

// File: sv/quaternion_vector_rotate_core.sv
// Top level of the quaternion vector rotation core.
`default_nettype none

// Rotates each 3D vector on the input stream by the configured quaternion
// (q * v * conj(q)), rounding to nearest with ties upward and clipping each
// component to VEC_WIDTH signed bits; tuser flags a clipped result. The
// quaternion resets to identity and is written via the cfg port (index 0-3:
// w, x, y, z; others ignored) by the user only while no item is in flight;
// the core does not enforce it. Throughput is one item per cycle unless
// stalled. Stages: quaternion products, rotation matrix, matrix-vector
// products, sum and round, saturate into the output register. Stalls ripple
// back stage by stage, so empty stages keep filling while the output waits.
module quaternion_vector_rotate_core #(
    parameter int VEC_WIDTH      = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [qvr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [qvr_pkg::QW-1:0]               cfg_data,
    // Input vectors
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // s_tdata: vec_x, vec_y, vec_z, zero fill to whole bytes
    input  wire logic [((3*VEC_WIDTH+7)/8)*8-1:0]     s_tdata,
    // Rotated vectors
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // m_tdata: rot_x, rot_y, rot_z, zero fill to whole bytes
    output logic [((3*VEC_WIDTH+7)/8)*8-1:0]          m_tdata,
    // m_tuser: saturated
    output logic [0:0]                                m_tuser
);
    import qvr_pkg::*;

    localparam int NSTAGE = 5;
    localparam int DW     = ((3 * VEC_WIDTH + 7) / 8) * 8;

    quat_t                       quat;
    logic signed [VEC_WIDTH-1:0] vec_in [3];
    logic signed [VEC_WIDTH-1:0] vec_d2 [3];
    coef_t                       coef [3][3];
    logic signed [VEC_WIDTH-1:0] rot [3];
    logic [2:0]                  sat;
    logic [NSTAGE-1:0]           valid_reg;
    logic [NSTAGE-1:0]           valid_next;
    logic [NSTAGE:0]             en;

    assign cfg_ready = 1'b1;

    qvr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .quat      (quat)
    );

    // Unpack the input item
    assign vec_in[0] = s_tdata[VEC_WIDTH-1:0];
    assign vec_in[1] = s_tdata[2*VEC_WIDTH-1:VEC_WIDTH];
    assign vec_in[2] = s_tdata[3*VEC_WIDTH-1:2*VEC_WIDTH];

    // Stage k loads when it is empty or its content moves on
    always_comb
    begin
        en[NSTAGE] = m_tready;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NSTAGE-1];

    qvr_coef #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_coef (
        .clk     (clk),
        .en1     (en[0]),
        .en2     (en[1]),
        .quat    (quat),
        .vec_in  (vec_in),
        .coef    (coef),
        .vec_out (vec_d2)
    );

    // One back-end lane per output component
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        qvr_row #(
            .VEC_WIDTH      (VEC_WIDTH),
            .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
        ) u_row (
            .clk  (clk),
            .en3  (en[2]),
            .en4  (en[3]),
            .en5  (en[4]),
            .coef (coef[r]),
            .vec  (vec_d2),
            .rot  (rot[r]),
            .sat  (sat[r])
        );
    end

    // Pack the result item
    assign m_tdata = DW'({rot[2], rot[1], rot[0]});
    assign m_tuser = |sat;

endmodule

`default_nettype wire

// File: tb/quaternion_vector_rotate_core_tb.sv
// Testbench of the quaternion vector rotation core: stream stimulus and a scoreboard.
`default_nettype none

module quaternion_vector_rotate_core_tb;

    import qvr_pkg::*;

    localparam int VW           = 16;
    localparam int QFB          = 14;
    localparam int DW           = ((3 * VW + 7) / 8) * 8;
    localparam int PIPE_LATENCY = 5;
    localparam int RAND_PHASES  = 12;
    localparam int CYCLE_LIMIT  = 400000;

    // Fixed-point scaling of the sandwich product
    localparam int     ROUND_BITS = 2 * QFB;
    localparam longint ROUND_HALF = 64'sd1 <<< (ROUND_BITS - 1);
    localparam longint VEC_MAX    = (64'sd1 <<< (VW - 1)) - 1;
    localparam longint VEC_MIN    = -VEC_MAX - 1;

    // First index past the register file
    localparam int CFG_IDX_FREE = int'(CFG_Q_Z) + 1;
    localparam int CFG_IDX_TOP  = (1 << CFG_IDX_W) - 1;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic                 sat;
    } rot_t;

    // DUT ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [QW-1:0]        cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DW-1:0]        s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DW-1:0]        m_tdata;
    logic [0:0]           m_tuser;

    // Quaternion as the core should hold it
    quat_t held_quat = {Q_W_RESET, 16'sd0, 16'sd0, 16'sd0};

    vec_t pending[$];
    rot_t rot_expected[$];
    vec_t cur_vec;
    rot_t want;
    rot_t got;

    bit idle_on = 1'b1;
    int src_gap = 0;
    int snk_gap = 0;

    int n_queued = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_clipped = 0;
    int n_errors = 0;
    int n_settings = 1;
    int cycle_count = 0;

    quaternion_vector_rotate_core #(
        .VEC_WIDTH      (VW),
        .QUAT_FRAC_BITS (QFB)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Rotate one vector by q * v * conj(q) in exact integers, round, clip
    function automatic rot_t rotate_vec(quat_t q, vec_t v);
        longint w, x, y, z;
        longint m[3][3];
        longint vin[3];
        longint acc;
        logic signed [VW-1:0] comp[3];
        rot_t r;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        vin[0] = v.x;
        vin[1] = v.y;
        vin[2] = v.z;
        m[0][0] = w * w + x * x - y * y - z * z;
        m[0][1] = 2 * (x * y - w * z);
        m[0][2] = 2 * (x * z + w * y);
        m[1][0] = 2 * (x * y + w * z);
        m[1][1] = w * w - x * x + y * y - z * z;
        m[1][2] = 2 * (y * z - w * x);
        m[2][0] = 2 * (x * z - w * y);
        m[2][1] = 2 * (y * z + w * x);
        m[2][2] = w * w - x * x - y * y + z * z;
        r.sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = m[i][0] * vin[0] + m[i][1] * vin[1] + m[i][2] * vin[2];
            // Half up, then floor
            acc = (acc + ROUND_HALF) >>> ROUND_BITS;
            if (acc > VEC_MAX)
            begin
                acc = VEC_MAX;
                r.sat = 1'b1;
            end
            else if (acc < VEC_MIN)
            begin
                acc = VEC_MIN;
                r.sat = 1'b1;
            end
            comp[i] = VW'(acc);
        end
        r.x = comp[0];
        r.y = comp[1];
        r.z = comp[2];
        return r;
    endfunction

    // Boundary and near-boundary values of a 16-bit signed field
    function automatic quat_part_t pick_edge();
        unique case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return -16'sd16384;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sd16384;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic quat_t make_quat(int w, int x, int y, int z);
        quat_t q;
        q.w = quat_part_t'(w);
        q.x = quat_part_t'(x);
        q.y = quat_part_t'(y);
        q.z = quat_part_t'(z);
        return q;
    endfunction

    // Mostly unit quaternions; some raw full-range and some corner values
    function automatic quat_t random_quat();
        real   a[4];
        real   mag;
        quat_t q;
        int    kind;
        kind = $urandom_range(0, 5);
        if (kind == 4)
            q = make_quat($urandom, $urandom, $urandom, $urandom);
        else if (kind == 5)
            q = {pick_edge(), pick_edge(), pick_edge(), pick_edge()};
        else
        begin
            do
            begin
                for (int k = 0; k < 4; k++)
                    a[k] = real'(int'($urandom_range(0, 65535)) - 32768);
                mag = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
            end while (mag < 1024.0);
            q = make_quat($rtoi(a[0] * 16384.0 / mag), $rtoi(a[1] * 16384.0 / mag),
                          $rtoi(a[2] * 16384.0 / mag), $rtoi(a[3] * 16384.0 / mag));
        end
        return q;
    endfunction

    task automatic push_vec(int a, int b, int c);
        vec_t v;
        v.x = VW'(a);
        v.y = VW'(b);
        v.z = VW'(c);
        pending.push_back(v);
        n_queued++;
    endtask

    // Full-range, small, boundary and single-axis vectors
    task automatic push_random_vec();
        int kind;
        int lone;
        int c[3];
        kind = $urandom_range(0, 9);
        lone = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
        begin
            if (kind <= 5)
                c[k] = int'($urandom_range(0, 65535)) - 32768;
            else if (kind <= 7)
                c[k] = int'($urandom_range(0, 128)) - 64;
            else if (kind == 8)
                c[k] = pick_edge();
            else
                c[k] = (k == lone) ? int'($urandom_range(0, 65535)) - 32768 : 0;
        end
        push_vec(c[0], c[1], c[2]);
    endtask

    // Write one register and track it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [QW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        unique case (idx)
            CFG_Q_W: held_quat.w = val;
            CFG_Q_X: held_quat.x = val;
            CFG_Q_Y: held_quat.y = val;
            CFG_Q_Z: held_quat.z = val;
            default: ;
        endcase
    endtask

    // Load a quaternion, sometimes with a stray write past the register file
    task automatic set_quat(quat_t q);
        write_reg(CFG_Q_W, q.w);
        write_reg(CFG_Q_X, q.x);
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_FREE, CFG_IDX_TOP)), QW'($urandom));
        write_reg(CFG_Q_Y, q.y);
        write_reg(CFG_Q_Z, q.z);
        n_settings++;
    endtask

    // Wait until every queued vector is taken and every result checked
    task automatic drain();
        while (n_accepted != n_queued || rot_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // Driver: present queued vectors, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap = 0;
        end
        else
        begin
            // Log the item taken at this edge
            if (s_tvalid && s_tready)
            begin
                rot_expected.push_back(rotate_vec(held_quat, cur_vec));
                n_accepted++;
            end
            // Offer the next item once the current one is gone
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (idle_on && pending.size() > 0 && $urandom_range(0, 9) == 0)
                begin
                    src_gap = $urandom_range(1, 16) - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    cur_vec = pending.pop_front();
                    s_tdata  <= {cur_vec.z, cur_vec.y, cur_vec.x};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each rotated vector, stall the output at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (rot_expected.size() == 0)
                begin
                    $error("rotated vector with none pending: m_tdata=%h", m_tdata);
                    n_errors++;
                end
                else
                begin
                    want  = rot_expected.pop_front();
                    got.x = m_tdata[VW-1:0];
                    got.y = m_tdata[2*VW-1:VW];
                    got.z = m_tdata[3*VW-1:2*VW];
                    got.sat = m_tuser[0];
                    if (got.x !== want.x)
                    begin
                        $error("rot_x mismatch: expected %0d, got %0d", want.x, got.x);
                        n_errors++;
                    end
                    if (got.y !== want.y)
                    begin
                        $error("rot_y mismatch: expected %0d, got %0d", want.y, got.y);
                        n_errors++;
                    end
                    if (got.z !== want.z)
                    begin
                        $error("rot_z mismatch: expected %0d, got %0d", want.z, got.z);
                        n_errors++;
                    end
                    if (got.sat !== want.sat)
                    begin
                        $error("saturated mismatch: expected %0d, got %0d", want.sat, got.sat);
                        n_errors++;
                    end
                    n_checked++;
                    if (want.sat)
                        n_clipped++;
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                snk_gap = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, rot_expected.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Identity from reset: extremes pass through unchanged
        push_vec(0, 0, 0);
        push_vec(32767, -32768, 1);
        push_vec(-1, -1, -1);
        push_vec(-32768, -32768, -32768);
        push_vec(32767, 32767, 32767);
        push_vec(21845, -21846, 0);
        drain();

        // Half-length quaternion scales by a quarter: rounding ties go upward
        set_quat(make_quat(8192, 0, 0, 0));
        write_reg(CFG_IDX_W'(CFG_IDX_TOP), '1);
        push_vec(2, -2, 1);
        push_vec(-1, -3, -6);
        push_vec(6, -5, -32768);
        push_vec(32767, -32767, 3);
        drain();

        // Most negative corner: length squared of 16, heavy clipping
        set_quat(make_quat(-32768, -32768, -32768, -32768));
        push_vec(1, 1, 1);
        push_vec(32767, 32767, 32767);
        push_vec(-32768, 0, 1);
        push_vec(2047, -2048, 2048);
        drain();

        // Quarter turn about z
        set_quat(make_quat(11585, 0, 0, 11585));
        push_vec(1000, 0, 0);
        push_vec(0, -1000, 0);
        push_vec(12345, -23456, 32767);
        drain();

        // Random quaternions and vectors, idling on in most phases
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_on <= ($urandom_range(0, 3) != 0);
            set_quat(random_quat());
            n = $urandom_range(100, 200);
            for (int k = 0; k < n; k++)
                push_random_vec();
            drain();
        end

        // Closing stretch at full rate
        idle_on <= 1'b0;
        set_quat(random_quat());
        for (int k = 0; k < 200; k++)
            push_random_vec();
        drain();

        if (rot_expected.size() != 0)
        begin
            $error("%0d rotated vectors never arrived", rot_expected.size());
            n_errors++;
        end
        $display("Checked %0d rotated vectors under %0d quaternion settings;", n_checked,
                 n_settings);
        $display("%0d of them came back clipped.", n_clipped);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
